// ----- src/otta_pkg.sv -----
// ----------------------------------------------------------------------------
// otta_pkg: shared types and constants of the obstacle track table
// Field widths, status codes, register indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package otta_pkg;

   localparam int MAX_OBSTACLES_DEF = 32;

   localparam int ID_W     = 16;
   localparam int POS_W    = 32;
   localparam int RADIUS_W = 16;
   localparam int VEL_W    = 16;
   localparam int FADE_W   = 8;
   localparam int THR_W    = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic OP_REPORT = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_UPDATED  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_SLOW     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_TICK     = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_RELOAD     = 1'd1;

   localparam logic [THR_W-1:0]  SPEED_THRESHOLD_RESET = 32'd2621;
   localparam logic [FADE_W-1:0] FADE_RELOAD_RESET     = 8'd11;

   typedef struct packed {
      logic                       operation;
      logic [ID_W-1:0]            obstacle_id;
      logic signed [POS_W-1:0]    pos_x;
      logic signed [POS_W-1:0]    pos_y;
      logic [RADIUS_W-1:0]        radius;
      logic signed [VEL_W-1:0]    vel_x;
      logic signed [VEL_W-1:0]    vel_y;
   } req_item_type;

   typedef struct packed {
      logic signed [POS_W-1:0]    pos_x;
      logic signed [POS_W-1:0]    pos_y;
      logic [RADIUS_W-1:0]        radius;
      logic signed [VEL_W-1:0]    vel_x;
      logic signed [VEL_W-1:0]    vel_y;
   } entry_payload_type;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_SQUARE,
      CTL_CHECK,
      CTL_SCAN,
      CTL_COMMIT,
      CTL_DONE
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic square;
      logic scan_en;
      logic commit;
      logic load_out;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic slow;
      logic scan_done;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- src/otta_if.sv -----
// ----------------------------------------------------------------------------
// otta_if: channel interfaces of the obstacle track table
// Report/tick request channel, result channel and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface otta_req_if
   import otta_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic                    operation;
   logic [ID_W-1:0]         obstacle_id;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic [RADIUS_W-1:0]     radius;
   logic signed [VEL_W-1:0] vel_x;
   logic signed [VEL_W-1:0] vel_y;

   modport source (output valid, operation, obstacle_id, pos_x, pos_y, radius,
                   vel_x, vel_y, input ready);
   modport sink   (input valid, operation, obstacle_id, pos_x, pos_y, radius,
                   vel_x, vel_y, output ready);
endinterface

interface otta_rsp_if
   import otta_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  evicted_count;
   logic [COUNT_W-1:0]  occupancy;

   modport source (output valid, status, evicted_count, occupancy, input ready);
   modport sink   (input valid, status, evicted_count, occupancy, output ready);
endinterface

interface otta_csr_if
   import otta_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/obstacle_track_table_aging_core.sv -----
// ----------------------------------------------------------------------------
// obstacle_track_table_aging_core: moving obstacle track table with aging
// Top level: register file, controller and datapath.
// ----------------------------------------------------------------------------
// Each item gives one result. Items are handled one at a time. A report
// whose squared speed is at or below the threshold skips the table sweep;
// a tracked report and a tick sweep the id and fade memories at one entry
// per cycle. A new item is taken while the previous result waits in the
// output register. Register writes are always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module obstacle_track_table_aging_core
   import otta_pkg::*;
   #(
   parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF
   )
   (
   input  wire logic  clock,
   input  wire logic  reset,
   otta_req_if.sink   req_chan,
   otta_rsp_if.source rsp_chan,
   otta_csr_if.sink   csr_chan
   );

   logic [THR_W-1:0]  speed_threshold_sq_ff, speed_threshold_sq_in;
   logic [FADE_W-1:0] fade_reload_ff, fade_reload_in;
   logic              csr_write;
   ctl_cmd_type       cmd;
   dp_status_type     status;
   req_item_type      req_item;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid;

   always_comb begin
      speed_threshold_sq_in = speed_threshold_sq_ff;
      fade_reload_in        = fade_reload_ff;
      if (csr_write) begin
         case (csr_chan.index)
            CSR_SPEED_THRESHOLD: speed_threshold_sq_in = csr_chan.data[THR_W-1:0];
            CSR_FADE_RELOAD:     fade_reload_in        = csr_chan.data[FADE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_threshold_sq_ff <= SPEED_THRESHOLD_RESET;
         fade_reload_ff        <= FADE_RELOAD_RESET;
      end else begin
         speed_threshold_sq_ff <= speed_threshold_sq_in;
         fade_reload_ff        <= fade_reload_in;
      end
   end

   assign req_item.operation   = req_chan.operation;
   assign req_item.obstacle_id = req_chan.obstacle_id;
   assign req_item.pos_x       = req_chan.pos_x;
   assign req_item.pos_y       = req_chan.pos_y;
   assign req_item.radius      = req_chan.radius;
   assign req_item.vel_x       = req_chan.vel_x;
   assign req_item.vel_y       = req_chan.vel_y;

   otta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   otta_datapath #(
      .MAX_OBSTACLES (MAX_OBSTACLES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_item           (req_item),
      .speed_threshold_sq (speed_threshold_sq_ff),
      .fade_reload        (fade_reload_ff),
      .out_status         (rsp_chan.status),
      .out_evicted_count  (rsp_chan.evicted_count),
      .out_occupancy      (rsp_chan.occupancy)
   );

endmodule

`default_nettype wire

// ----- src/otta_ctrl.sv -----
// ----------------------------------------------------------------------------
// otta_ctrl: sequencing controller of the obstacle track table
// Walks one item through square, threshold check, table sweep, commit and
// result load as they apply. Owns the request ready and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module otta_ctrl
   import otta_pkg::*;
   (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output ctl_cmd_type        cmd
   );

   ctl_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE: begin
            if (req_valid) begin
               state_in = CTL_SQUARE;
            end
         end
         CTL_SQUARE: begin
            state_in = status.is_tick ? CTL_SCAN : CTL_CHECK;
         end
         CTL_CHECK: begin
            state_in = status.slow ? CTL_DONE : CTL_SCAN;
         end
         CTL_SCAN: begin
            if (status.scan_done) begin
               state_in = status.is_tick ? CTL_DONE : CTL_COMMIT;
            end
         end
         CTL_COMMIT: begin
            state_in = CTL_DONE;
         end
         CTL_DONE: begin
            if (out_free) begin
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         CTL_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         CTL_SQUARE: begin
            cmd.square = 1'b1;
         end
         CTL_CHECK: begin
         end
         CTL_SCAN: begin
            cmd.scan_en = 1'b1;
         end
         CTL_COMMIT: begin
            cmd.commit = 1'b1;
         end
         CTL_DONE: begin
            cmd.load_out = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/otta_datapath.sv -----
// ----------------------------------------------------------------------------
// otta_datapath: table storage and per-entry processing
// Holds the captured item, the speed squares, the entry memories and valid
// bits, the sweep pointer with its registered read stage, the match and free
// slot trackers, the occupancy and eviction counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module otta_datapath
   import otta_pkg::*;
   #(
   parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF
   )
   (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctl_cmd_type       cmd,
   output dp_status_type          status,
   input  wire req_item_type      req_item,
   input  wire logic [THR_W-1:0]  speed_threshold_sq,
   input  wire logic [FADE_W-1:0] fade_reload,
   output logic [STATUS_W-1:0]    out_status,
   output logic [COUNT_W-1:0]     out_evicted_count,
   output logic [COUNT_W-1:0]     out_occupancy
   );

   localparam int IDX_W = $clog2(MAX_OBSTACLES);
   localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
   localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_OBSTACLES - 1);

   req_item_type              req_ff, req_in;
   logic [THR_W-1:0]          sq_x_ff, sq_x_in, sq_y_ff, sq_y_in;
   logic [IDX_W-1:0]          addr_ff, addr_in;
   logic                      issue_done_ff, issue_done_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]          rd_idx_ff, rd_idx_in;
   logic [ID_W-1:0]           rd_id_ff;
   logic [FADE_W-1:0]         rd_fade_ff;
   logic [MAX_OBSTACLES-1:0]  valid_ff, valid_in;
   logic                      match_found_ff, match_found_in;
   logic [IDX_W-1:0]          match_idx_ff, match_idx_in;
   logic                      free_found_ff, free_found_in;
   logic [IDX_W-1:0]          free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]          occ_ff, occ_in;
   logic [CNT_W-1:0]          evict_ff, evict_in;
   logic [STATUS_W-1:0]       res_status_ff, res_status_in;
   logic [STATUS_W-1:0]       out_status_ff;
   logic [COUNT_W-1:0]        out_evicted_ff, out_occ_ff;

   logic [ID_W-1:0]           id_mem   [MAX_OBSTACLES];
   logic [FADE_W-1:0]         fade_mem [MAX_OBSTACLES];
   entry_payload_type         pay_mem  [MAX_OBSTACLES];

   logic                      id_we, pay_we, fade_we;
   logic [IDX_W-1:0]          slot, fade_waddr;
   logic [FADE_W-1:0]         fade_wdata;
   logic signed [2*VEL_W-1:0] prod_x, prod_y;
   logic [THR_W:0]            speed_sum;
   logic [EXT_W-1:0]          evict_ext, occ_ext;
   entry_payload_type         payload;

   assign prod_x    = req_ff.vel_x * req_ff.vel_x;
   assign prod_y    = req_ff.vel_y * req_ff.vel_y;
   assign speed_sum = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};

   assign status.is_tick   = (req_ff.operation == OP_TICK);
   assign status.slow      = (speed_sum <= {1'b0, speed_threshold_sq});
   assign status.scan_done = issue_done_ff && !rd_vld_ff;

   assign payload.pos_x  = req_ff.pos_x;
   assign payload.pos_y  = req_ff.pos_y;
   assign payload.radius = req_ff.radius;
   assign payload.vel_x  = req_ff.vel_x;
   assign payload.vel_y  = req_ff.vel_y;

   always_comb begin
      req_in         = req_ff;
      sq_x_in        = sq_x_ff;
      sq_y_in        = sq_y_ff;
      addr_in        = addr_ff;
      issue_done_in  = issue_done_ff;
      rd_vld_in      = cmd.scan_en && !issue_done_ff;
      rd_idx_in      = addr_ff;
      valid_in       = valid_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      occ_in         = occ_ff;
      evict_in       = evict_ff;
      res_status_in  = res_status_ff;
      id_we          = 1'b0;
      pay_we         = 1'b0;
      fade_we        = 1'b0;
      slot           = match_idx_ff;
      fade_waddr     = rd_idx_ff;
      fade_wdata     = rd_fade_ff - FADE_W'(1);

      if (cmd.capture) begin
         req_in         = req_item;
         addr_in        = '0;
         issue_done_in  = 1'b0;
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         evict_in       = '0;
         res_status_in  = (req_item.operation == OP_TICK) ? STATUS_TICK : STATUS_SLOW;
      end

      if (cmd.square) begin
         sq_x_in = THR_W'(unsigned'(prod_x));
         sq_y_in = THR_W'(unsigned'(prod_y));
      end

      if (cmd.scan_en && !issue_done_ff) begin
         if (addr_ff == LAST_IDX) begin
            issue_done_in = 1'b1;
         end else begin
            addr_in = addr_ff + IDX_W'(1);
         end
      end

      if (rd_vld_ff) begin
         if (req_ff.operation == OP_TICK) begin
            if (valid_ff[rd_idx_ff]) begin
               if (rd_fade_ff <= FADE_W'(1)) begin
                  valid_in[rd_idx_ff] = 1'b0;
                  evict_in            = evict_ff + CNT_W'(1);
                  occ_in              = occ_ff - CNT_W'(1);
               end else begin
                  fade_we = 1'b1;
               end
            end
         end else begin
            if (valid_ff[rd_idx_ff] && rd_id_ff == req_ff.obstacle_id && !match_found_ff) begin
               match_found_in = 1'b1;
               match_idx_in   = rd_idx_ff;
            end
            if (!valid_ff[rd_idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = rd_idx_ff;
            end
         end
      end

      if (cmd.commit) begin
         if (match_found_ff) begin
            slot          = match_idx_ff;
            res_status_in = STATUS_UPDATED;
         end else if (free_found_ff) begin
            slot          = free_idx_ff;
            res_status_in = STATUS_INSERTED;
            occ_in        = occ_ff + CNT_W'(1);
         end else begin
            res_status_in = STATUS_FULL;
         end
         if (match_found_ff || free_found_ff) begin
            valid_in[slot] = 1'b1;
            id_we          = 1'b1;
            pay_we         = 1'b1;
            fade_we        = 1'b1;
            fade_waddr     = slot;
            fade_wdata     = fade_reload;
         end
      end
   end

   assign evict_ext = EXT_W'(evict_ff);
   assign occ_ext   = EXT_W'(occ_ff);

   always_ff @(posedge clock) begin
      if (id_we) begin
         id_mem[slot] <= req_ff.obstacle_id;
      end
      rd_id_ff <= id_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (fade_we) begin
         fade_mem[fade_waddr] <= fade_wdata;
      end
      rd_fade_ff <= fade_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (pay_we) begin
         pay_mem[slot] <= payload;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      sq_x_ff      <= sq_x_in;
      sq_y_ff      <= sq_y_in;
      addr_ff      <= addr_in;
      rd_idx_ff    <= rd_idx_in;
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      if (cmd.load_out) begin
         out_status_ff  <= res_status_ff;
         out_evicted_ff <= (evict_ext > EXT_W'(63)) ? COUNT_W'(63) : evict_ext[COUNT_W-1:0];
         out_occ_ff     <= (occ_ext > EXT_W'(63)) ? COUNT_W'(63) : occ_ext[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_done_ff  <= 1'b1;
         rd_vld_ff      <= 1'b0;
         valid_ff       <= '0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         occ_ff         <= '0;
         evict_ff       <= '0;
         res_status_ff  <= STATUS_SLOW;
      end else begin
         issue_done_ff  <= issue_done_in;
         rd_vld_ff      <= rd_vld_in;
         valid_ff       <= valid_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         occ_ff         <= occ_in;
         evict_ff       <= evict_in;
         res_status_ff  <= res_status_in;
      end
   end

   assign out_status        = out_status_ff;
   assign out_evicted_count = out_evicted_ff;
   assign out_occupancy     = out_occ_ff;

endmodule

`default_nettype wire
